/* rtl/assert_macros.svh */
// assertion macros used by the checker file lcdt_checker.sv
// no dependencies; clock and active-low reset are passed in at each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/lcdt_pkg.sv */
// types, codes and default timing constants of the lcd line timing controller
// no dependencies
`default_nettype none

package lcdt_pkg;

    localparam int DEF_DOTS_PER_LINE = 456;
    localparam int DEF_VISIBLE_LINES = 144;
    localparam int DEF_LAST_LINE     = 153;

    localparam int SCAN_END_DOT = 80;
    localparam int DRAW_END_DOT = 252;

    localparam int MC_W    = 6;
    localparam int DOTS_W  = 8;
    localparam int DOT_W   = 9;
    localparam int LINE_W  = 8;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 8;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SCAN   = 2'd2,
        MODE_DRAW   = 2'd3
    } t_mode;

    typedef enum logic [CIDX_W-1:0] {
        CFG_COMPARE_LINE  = 3'd0,
        CFG_HBLANK_EN     = 3'd1,
        CFG_VBLANK_EN     = 3'd2,
        CFG_SCAN_EN       = 3'd3,
        CFG_MATCH_EN      = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [LINE_W-1:0] compare_line;
        logic              hblank_irq_enable;
        logic              vblank_stat_enable;
        logic              scan_irq_enable;
        logic              match_irq_enable;
    } t_cfg;

    typedef struct packed {
        logic [DOTS_W-1:0] dot_cycles;
        t_mode             lcd_mode;
        logic [LINE_W-1:0] current_line;
        logic              coincidence;
        logic              vblank_request;
        logic              stat_request;
        logic              scan_request;
        logic              render_request;
        logic              window_reset;
    } t_result;

endpackage

`default_nettype wire

/* rtl/lcdt_core.sv */
// dot and line counters, mode tracking and result register of one step
// depends on lcdt_pkg
`default_nettype none

module lcdt_core import lcdt_pkg::*; #(
    parameter int DOTS_PER_LINE = DEF_DOTS_PER_LINE,
    parameter int VISIBLE_LINES = DEF_VISIBLE_LINES,
    parameter int LAST_LINE     = DEF_LAST_LINE
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [MC_W-1:0] i_machine_cycles,
    input  wire t_cfg            i_cfg,
    output t_result              o_result
);

    logic [DOT_W-1:0]  r_dot;
    logic [LINE_W-1:0] r_line;
    t_mode             r_mode;
    logic              r_scan_done;
    logic              r_render_done;
    t_result           r_result;

    logic [DOT_W-1:0]  n_dot;
    logic [LINE_W-1:0] n_line;
    t_mode             n_mode;
    logic              n_scan_done;
    logic              n_render_done;
    t_result           n_result;

    logic [DOTS_W-1:0] w_dots_in;
    logic [DOT_W:0]    w_dot_sum;
    logic              w_wrap;
    logic [LINE_W:0]   w_line_adv;
    logic [LINE_W:0]   w_cmp_ext;
    logic              w_stat;
    logic              w_vbl;
    logic              w_scan_req;
    logic              w_render_req;

    always_comb begin
        w_dots_in  = {i_machine_cycles, 2'b00};
        w_dot_sum  = {1'b0, r_dot} + {2'b00, w_dots_in};
        w_wrap     = (w_dot_sum >= (DOT_W+1)'(DOTS_PER_LINE));
        n_dot      = w_wrap ? DOT_W'(w_dot_sum - (DOT_W+1)'(DOTS_PER_LINE))
                            : w_dot_sum[DOT_W-1:0];
        w_line_adv = {1'b0, r_line} + {{LINE_W{1'b0}}, w_wrap};
        w_cmp_ext  = {1'b0, i_cfg.compare_line};
        n_scan_done   = r_scan_done && !w_wrap;
        n_render_done = r_render_done;
        n_mode     = r_mode;
        n_line     = w_line_adv[LINE_W-1:0];
        w_vbl      = 1'b0;
        w_scan_req   = 1'b0;
        w_render_req = 1'b0;
        w_stat     = w_wrap && (w_line_adv == w_cmp_ext) && i_cfg.match_irq_enable;

        if (w_line_adv < (LINE_W+1)'(VISIBLE_LINES)) begin
            if (n_dot <= DOT_W'(SCAN_END_DOT)) begin
                if (r_mode == MODE_VBLANK && i_cfg.scan_irq_enable) begin
                    w_stat = 1'b1;
                end
                n_mode = MODE_SCAN;
            end else if (n_dot <= DOT_W'(DRAW_END_DOT)) begin
                n_mode = MODE_DRAW;
            end else begin
                if (r_mode == MODE_DRAW && i_cfg.hblank_irq_enable) begin
                    w_stat = 1'b1;
                end
                n_mode = MODE_HBLANK;
            end
        end

        if (w_line_adv == (LINE_W+1)'(VISIBLE_LINES)) begin
            n_mode = MODE_VBLANK;
            w_vbl  = 1'b1;
            if (i_cfg.vblank_stat_enable) begin
                w_stat = 1'b1;
            end
        end else if (w_line_adv > (LINE_W+1)'(LAST_LINE)) begin
            // frame wrap forces oam scan whatever the dot position
            n_mode = MODE_SCAN;
            n_line = '0;
            if (i_cfg.compare_line == '0 && i_cfg.match_irq_enable) begin
                w_stat = 1'b1;
            end
        end

        case (n_mode)
            MODE_SCAN: begin
                if (!n_scan_done) begin
                    w_scan_req    = 1'b1;
                    n_scan_done   = 1'b1;
                    n_render_done = 1'b0;
                end
            end
            MODE_DRAW: begin
                if (!n_render_done) begin
                    w_render_req  = 1'b1;
                    n_render_done = 1'b1;
                end
            end
            default: begin
            end
        endcase

        n_result.dot_cycles     = w_dots_in;
        n_result.lcd_mode       = n_mode;
        n_result.current_line   = n_line;
        n_result.coincidence    = (n_line == i_cfg.compare_line);
        n_result.vblank_request = w_vbl;
        n_result.stat_request   = w_stat;
        n_result.scan_request   = w_scan_req;
        n_result.render_request = w_render_req;
        n_result.window_reset   = w_vbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot         <= '0;
            r_line        <= '0;
            r_mode        <= MODE_VBLANK;
            r_scan_done   <= 1'b0;
            r_render_done <= 1'b0;
        end else if (i_step) begin
            r_dot         <= n_dot;
            r_line        <= n_line;
            r_mode        <= n_mode;
            r_scan_done   <= n_scan_done;
            r_render_done <= n_render_done;
        end
    end

    // result payload, held while the output is stalled
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

/* rtl/lcd_line_timing_controller_top.sv */
// top level of the lcd line timing controller: handshakes, input register,
// configuration registers; depends on lcdt_pkg and lcdt_core
//
//  channel  direction  handshake                       payload
//  input    in         i_valid / o_stall               i_machine_cycles
//  result   out        o_valid / i_stall               o_dot_cycles .. o_window_reset
//  config   in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// one step per clock sustained while the result is not stalled; an accepted input
// waits in the input register, which feeds the counter update into the result register
// the dot/line/mode update is combinational and registered back onto itself in lcdt_core
// synchronous reset clears counters, mode (vblank), one-shot flags and config
// a stalled result holds in the output register; o_stall rises only when the
// input register is also full, so one transaction can wait behind it
`default_nettype none

module lcd_line_timing_controller_top import lcdt_pkg::*; #(
    parameter int DOTS_PER_LINE = DEF_DOTS_PER_LINE,
    parameter int VISIBLE_LINES = DEF_VISIBLE_LINES,
    parameter int LAST_LINE     = DEF_LAST_LINE
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [MC_W-1:0]    i_machine_cycles,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [DOTS_W-1:0]       o_dot_cycles,
    output logic [1:0]              o_lcd_mode,
    output logic [LINE_W-1:0]       o_current_line,
    output logic                    o_coincidence,
    output logic                    o_vblank_request,
    output logic                    o_stat_request,
    output logic                    o_scan_request,
    output logic                    o_render_request,
    output logic                    o_window_reset,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CIDX_W-1:0]  i_cfg_index,
    input  wire logic [CDATA_W-1:0] i_cfg_data
);

    logic            r_in_valid;
    logic [MC_W-1:0] r_in_mc;
    logic            r_out_valid;
    t_cfg            r_cfg;
    logic            n_in_valid;
    logic            n_out_valid;
    logic            w_out_free;
    logic            w_step;
    logic            w_in_take;
    t_result         w_result;

    always_comb begin
        w_out_free  = !r_out_valid || !i_stall;
        w_step      = r_in_valid && w_out_free;
        o_stall     = r_in_valid && !w_out_free;
        w_in_take   = i_valid && !o_stall;
        n_in_valid  = w_in_take || (r_in_valid && !w_step);
        n_out_valid = w_step || (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_mc <= i_machine_cycles;
        end
    end

    // register writes; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_COMPARE_LINE: r_cfg.compare_line       <= i_cfg_data[LINE_W-1:0];
                CFG_HBLANK_EN:    r_cfg.hblank_irq_enable  <= i_cfg_data[0];
                CFG_VBLANK_EN:    r_cfg.vblank_stat_enable <= i_cfg_data[0];
                CFG_SCAN_EN:      r_cfg.scan_irq_enable    <= i_cfg_data[0];
                CFG_MATCH_EN:     r_cfg.match_irq_enable   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    lcdt_core #(
        .DOTS_PER_LINE (DOTS_PER_LINE),
        .VISIBLE_LINES (VISIBLE_LINES),
        .LAST_LINE     (LAST_LINE)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_machine_cycles (r_in_mc),
        .i_cfg            (r_cfg),
        .o_result         (w_result)
    );

    assign o_valid          = r_out_valid;
    assign o_dot_cycles     = w_result.dot_cycles;
    assign o_lcd_mode       = w_result.lcd_mode;
    assign o_current_line   = w_result.current_line;
    assign o_coincidence    = w_result.coincidence;
    assign o_vblank_request = w_result.vblank_request;
    assign o_stat_request   = w_result.stat_request;
    assign o_scan_request   = w_result.scan_request;
    assign o_render_request = w_result.render_request;
    assign o_window_reset   = w_result.window_reset;

endmodule

`default_nettype wire

/* rtl/lcdt_checker.sv */
// port-level assertions for the lcd line timing controller, bound to the top
// depends on lcdt_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module lcdt_checker import lcdt_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_stall,
    input wire logic              o_valid,
    input wire logic [DOTS_W-1:0] o_dot_cycles,
    input wire logic [1:0]        o_lcd_mode,
    input wire logic [LINE_W-1:0] o_current_line,
    input wire logic              o_vblank_request,
    input wire logic              o_scan_request,
    input wire logic              o_render_request,
    input wire logic              o_window_reset
);

    // vblank line always reports vblank mode and the window clear together
    `ASSERT_IMP(a_vbl_mode, i_clk, i_rst_n, o_valid && o_vblank_request, o_lcd_mode == MODE_VBLANK && o_window_reset)
    // one-shot requests only come with their own mode
    `ASSERT_IMP(a_scan_mode, i_clk, i_rst_n, o_valid && o_scan_request, o_lcd_mode == MODE_SCAN)
    `ASSERT_IMP(a_render_mode, i_clk, i_rst_n, o_valid && o_render_request, o_lcd_mode == MODE_DRAW)
    // a stalled transaction keeps its line and mode
    `ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_current_line) && $stable(o_lcd_mode) && $stable(o_dot_cycles))

endmodule

bind lcd_line_timing_controller_top lcdt_checker u_lcdt_checker (.*);

`default_nettype wire
